>>> hw/rtl/vlis_pkg.sv
// Shared constants and types for the vector length / integer square root block.
// No dependencies.
package vlis_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int LENGTH_WIDTH    = 32;

  // operation codes for the shared arithmetic unit
  localparam int OP_W = 2;
  typedef logic [OP_W-1:0] op_t;

  localparam op_t OP_HOLD   = 2'd0;
  localparam op_t OP_SQUARE = 2'd1;
  localparam op_t OP_ADD    = 2'd2;
  localparam op_t OP_ROOT   = 2'd3;

endpackage

>>> hw/rtl/vector_length_integer_sqrt.sv
// Top level: floor(sqrt(x^2 + y^2)) of two signed coordinates, stream in/out.
// Sequencer, input magnitudes and output register; uses vlis_pkg and vlis_root_unit.
//
//   channel | dir | tdata fields (low bit up)                     | tuser/tlast
//   s_*     | in  | coord_x [W-1:0], coord_y [2W-1:W], zero pad    | none
//   m_*     | out | length [31:0]                                 | none
//
// Each word goes through two squaring passes and an add in the shared arithmetic
// unit, then one root step per cycle on the radicand adder/comparator, then the
// load into the output register.
// s_tready is high only while the sequencer is idle; a held result does not
// block the next accept, but the next result waits until it is taken.
// rst is synchronous and clears the sequencer and the output valid.
module vector_length_integer_sqrt
  import vlis_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  localparam int IN_W = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [IN_W-1:0]         s_tdata,   // coord_x, coord_y, zero pad
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [LENGTH_WIDTH-1:0] m_tdata    // length
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQX  = 3'd1;
  localparam logic [2:0] S_SQY  = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_ROOT = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  logic [COORD_WIDTH-1:0] coord_x;
  logic [COORD_WIDTH-1:0] coord_y;
  logic [COORD_WIDTH-1:0] mag_x;
  logic [COORD_WIDTH-1:0] mag_y;
  logic [COORD_WIDTH-1:0] mag_x_in;
  logic [COORD_WIDTH-1:0] mag_y_in;

  op_t                    op;
  logic [COORD_WIDTH-1:0] operand;
  logic [COORD_WIDTH-1:0] root_res;
  logic                   last;
  logic                   s_accept;
  logic                   out_load;

  assign coord_x  = s_tdata[COORD_WIDTH-1:0];
  assign coord_y  = s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
  // most negative value maps to 2^(W-1), which still fits W bits unsigned
  assign mag_x_in = coord_x[COORD_WIDTH-1] ? (~coord_x + 1'b1) : coord_x;
  assign mag_y_in = coord_y[COORD_WIDTH-1] ? (~coord_y + 1'b1) : coord_y;

  assign s_tready = (state == S_IDLE);
  assign s_accept = s_tvalid && s_tready;
  assign out_load = (state == S_DONE) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (s_accept) begin
      mag_x <= mag_x_in;
      mag_y <= mag_y_in;
    end
  end

  always_comb begin
    state_next = state;
    op         = OP_HOLD;
    operand    = mag_x;
    case (state)
      S_IDLE: begin
        if (s_accept) state_next = S_SQX;
      end
      S_SQX: begin
        op         = OP_SQUARE;
        state_next = S_SQY;
      end
      S_SQY: begin
        op         = OP_SQUARE;
        operand    = mag_y;
        state_next = S_ADD;
      end
      S_ADD: begin
        op         = OP_ADD;
        state_next = S_ROOT;
      end
      S_ROOT: begin
        op = OP_ROOT;
        if (last) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  vlis_root_unit #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_root (
    .clk      (clk),
    .op       (op),
    .operand  (operand),
    .root_res (root_res),
    .last     (last)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) m_tdata <= LENGTH_WIDTH'(root_res);
  end

`ifndef ASSERT_OFF
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> (state == S_SQX))
    else $error("accepted word did not start the squaring pass");

  a_last_step_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROOT) && last |=> (state == S_DONE))
    else $error("root iteration did not stop at the last trial bit");

  a_valid_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == S_DONE))
    else $error("result shown without a finished root");

  a_length_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata >> COORD_WIDTH) == '0))
    else $error("length wider than the coordinate width");
`endif

endmodule

>>> hw/rtl/vlis_root_unit.sv
// Shared arithmetic unit: one squarer, one adder, one base-four root step.
// Holds the product, radicand, partial root and trial bit. Depends on vlis_pkg.
module vlis_root_unit
  import vlis_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  op_t                    op,
  input  logic [COORD_WIDTH-1:0] operand,  // magnitude to square
  output logic [COORD_WIDTH-1:0] root_res,
  output logic                   last      // trial bit at position zero
);

  localparam int RAD_W = 2 * COORD_WIDTH;
  localparam logic [RAD_W-1:0] TRIAL_TOP = RAD_W'(1) << (RAD_W - 2);

  logic [RAD_W-1:0] prod;
  logic [RAD_W-1:0] rad;
  logic [RAD_W-1:0] root;
  logic [RAD_W-1:0] trial;

  logic [RAD_W-1:0] sq;
  logic [RAD_W-1:0] sum;
  logic             fits;

  assign sq   = RAD_W'(operand) * RAD_W'(operand);
  assign sum  = root + trial;
  assign fits = (rad >= sum);

  always_ff @(posedge clk) begin
    case (op)
      OP_SQUARE: begin
        prod <= sq;
        rad  <= prod;  // first square is moved over on the second pass
      end
      OP_ADD: begin
        rad   <= rad + prod;
        root  <= '0;
        trial <= TRIAL_TOP;
      end
      OP_ROOT: begin
        if (fits) begin
          rad  <= rad - sum;
          root <= (root >> 1) + trial;
        end else begin
          root <= root >> 1;
        end
        trial <= trial >> 2;
      end
      default: begin
      end
    endcase
  end

  assign root_res = root[COORD_WIDTH-1:0];
  assign last     = trial[0];

endmodule
